FILE: hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the call state table: line count, widths,
// line modes, event codes and the layout of one table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

   // number of lines and index widths
   localparam int NUM_LINES = 8;
   localparam int LINE_W    = 3;
   localparam int ADDR_W    = $clog2(NUM_LINES);
   localparam int CMD_W     = 2;
   localparam int EVENT_W   = 3;
   localparam int MODE_W    = 3;

   // commands on the request channel
   typedef enum logic [CMD_W-1:0] {
      CMD_CONNECT = 2'd0,
      CMD_ANSWER  = 2'd1,
      CMD_HANGUP  = 2'd2
   } cmd_type;

   // per-line call mode
   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE      = 3'd0,
      MODE_WAITING   = 3'd1,
      MODE_CONNECTED = 3'd2,
      MODE_RINGING   = 3'd3,
      MODE_TALKING   = 3'd4
   } mode_type;

   // event codes on the response channel
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE      = 3'd0,
      EV_RINGING   = 3'd1,
      EV_BUSY      = 3'd2,
      EV_CONNECTED = 3'd3,
      EV_REJECTED  = 3'd4,
      EV_ABANDONED = 3'd5,
      EV_ENDED     = 3'd6
   } event_type;

   // one table entry: mode, partner link and link flag
   typedef struct packed {
      mode_type           mode;
      logic [LINE_W-1:0]  pidx;
      logic               pv;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

FILE: hdl/cst_ram.sv
// ----------------------------------------------------------------------------
// cst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/call_state_table_top.sv
// Each accepted request beat runs the caller read (S_RDA), the second read,
// decision and first write (S_RDB) and the second write (S_WR2), then the
// response beat is registered. One command is in flight at a time: the table
// RAM has one read and one write port, so the two reads and two writes of each
// command take turns; a stalled response beat holds the next command in S_WR2.
// Reset clears the sequencer and the per-line valid flags: all lines read idle.
// ----------------------------------------------------------------------------
// call_state_table_top
// Per-line call state and partner link of a small exchange, kept in a RAM
// and updated by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module call_state_table_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cst_pkg::CMD_W-1:0]    req_command,
   input  logic [cst_pkg::LINE_W-1:0]   req_caller_line,
   input  logic [cst_pkg::LINE_W-1:0]   req_callee_line,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cst_pkg::EVENT_W-1:0]  rsp_event_res,
   output logic [cst_pkg::LINE_W-1:0]   rsp_line_id,
   output logic [cst_pkg::LINE_W-1:0]   rsp_other_line
);

   import cst_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RDA,
      S_RDB,
      S_WR2
   } state_type;

   state_type          state_ff;
   cmd_type            cmd_ff;
   logic [LINE_W-1:0]  a_ff;
   logic [LINE_W-1:0]  b_ff;
   entry_type          ent_a_ff;
   logic [ADDR_W-1:0]  addr2_ff;
   logic               wr2_en_ff;
   logic [ADDR_W-1:0]  wr2_addr_ff;
   entry_type          wr2_data_ff;
   event_type          ev_ff;
   logic [LINE_W-1:0]  other_ff;
   logic               rsp_valid_ff;
   event_type          rsp_event_ff;
   logic [LINE_W-1:0]  rsp_line_ff;
   logic [LINE_W-1:0]  rsp_other_ff;
   logic               vld_ff [NUM_LINES];

   logic [ADDR_W-1:0]  a_idx;
   logic [ADDR_W-1:0]  addr2_in;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   entry_type          ram_wr_data;
   entry_type          ent_a_rd;
   entry_type          ent_2_rd;
   logic               a_rd_linked;

   // decision outputs
   logic               a_ok;
   logic               b_ok;
   logic               linked;
   logic [LINE_W-1:0]  p_line;
   event_type          ev_in;
   logic [LINE_W-1:0]  other_in;
   logic               wr1_en;
   logic [ADDR_W-1:0]  wr1_addr;
   entry_type          wr1_data;
   logic               wr2_en_in;
   logic [ADDR_W-1:0]  wr2_addr_in;
   entry_type          wr2_data_in;
   logic               rsp_free;

   assign a_idx = a_ff[ADDR_W-1:0];

   // entries never written read as idle and unlinked
   assign ent_a_rd = vld_ff[a_idx] ? entry_type'(ram_rd_data) : '0;
   assign ent_2_rd = vld_ff[addr2_ff] ? entry_type'(ram_rd_data) : '0;

   // second address: callee for connect, linked partner otherwise
   assign a_rd_linked = ent_a_rd.pv && (int'(ent_a_rd.pidx) < NUM_LINES);
   always_comb begin
      if (cmd_ff == CMD_CONNECT) begin
         addr2_in = b_ff[ADDR_W-1:0];
      end else if (a_rd_linked) begin
         addr2_in = ent_a_rd.pidx[ADDR_W-1:0];
      end else begin
         addr2_in = '0;
      end
   end

   // read address: caller on the request beat, second line after that
   assign ram_rd_addr = (state_ff == S_IDLE) ? req_caller_line[ADDR_W-1:0] : addr2_in;

   // command decision on the caller entry and the second entry
   assign a_ok   = int'(a_ff) < NUM_LINES;
   assign b_ok   = int'(b_ff) < NUM_LINES;
   assign linked = ent_a_ff.pv && (int'(ent_a_ff.pidx) < NUM_LINES);
   assign p_line = linked ? ent_a_ff.pidx : '0;

   always_comb begin
      ev_in       = EV_NONE;
      other_in    = '0;
      wr1_en      = 1'b0;
      wr1_addr    = a_idx;
      wr1_data    = '0;
      wr2_en_in   = 1'b0;
      wr2_addr_in = a_idx;
      wr2_data_in = '0;
      if (a_ok) begin
         case (cmd_ff)
            CMD_CONNECT: begin
               if (b_ok && b_ff != a_ff && ent_a_ff.mode == MODE_IDLE) begin
                  other_in = b_ff;
                  if (ent_2_rd.mode == MODE_IDLE) begin
                     ev_in       = EV_RINGING;
                     wr1_en      = 1'b1;
                     wr1_addr    = a_idx;
                     wr1_data    = '{mode: MODE_WAITING, pidx: b_ff, pv: 1'b1};
                     wr2_en_in   = 1'b1;
                     wr2_addr_in = b_ff[ADDR_W-1:0];
                     wr2_data_in = '{mode: MODE_RINGING, pidx: a_ff, pv: 1'b1};
                  end else begin
                     ev_in = EV_BUSY;
                  end
               end
            end
            CMD_ANSWER: begin
               if (ent_a_ff.mode == MODE_RINGING && linked) begin
                  ev_in       = EV_CONNECTED;
                  other_in    = p_line;
                  wr1_en      = 1'b1;
                  wr1_addr    = a_idx;
                  wr1_data    = '{mode: MODE_TALKING, pidx: ent_a_ff.pidx, pv: ent_a_ff.pv};
                  wr2_en_in   = 1'b1;
                  wr2_addr_in = p_line[ADDR_W-1:0];
                  wr2_data_in = '{mode: MODE_CONNECTED, pidx: ent_2_rd.pidx,
                                  pv: ent_2_rd.pv};
               end
            end
            CMD_HANGUP: begin
               if (ent_a_ff.mode == MODE_WAITING || ent_a_ff.mode == MODE_RINGING ||
                   ent_a_ff.mode == MODE_CONNECTED || ent_a_ff.mode == MODE_TALKING) begin
                  if (linked) begin
                     if (ent_a_ff.mode == MODE_RINGING) begin
                        ev_in = EV_REJECTED;
                     end else if (ent_a_ff.mode == MODE_WAITING) begin
                        ev_in = EV_ABANDONED;
                     end else begin
                        ev_in = EV_ENDED;
                     end
                     other_in = p_line;
                     // partner goes idle first, then the caller
                     wr1_en   = 1'b1;
                     wr1_addr = p_line[ADDR_W-1:0];
                     wr1_data = '0;
                  end
                  wr2_en_in   = 1'b1;
                  wr2_addr_in = a_idx;
                  wr2_data_in = '0;
               end
            end
            default: begin
               ev_in = EV_NONE;
            end
         endcase
      end
   end

   // table write port: first write while deciding, second in the cycle after
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr1_addr;
      ram_wr_data = wr1_data;
      if (state_ff == S_RDB) begin
         ram_wr_en = wr1_en;
      end else if (state_ff == S_WR2) begin
         ram_wr_en   = wr2_en_ff;
         ram_wr_addr = wr2_addr_ff;
         ram_wr_data = wr2_data_ff;
      end
   end

   cst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_LINES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // sequencer, held operands and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wr2_en_ff    <= 1'b0;
         for (int i = 0; i < NUM_LINES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_wr_en) begin
            vld_ff[ram_wr_addr] <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= cmd_type'(req_command);
                  a_ff     <= req_caller_line;
                  b_ff     <= req_callee_line;
                  state_ff <= S_RDA;
               end
            end
            S_RDA: begin
               ent_a_ff <= ent_a_rd;
               addr2_ff <= addr2_in;
               state_ff <= S_RDB;
            end
            S_RDB: begin
               ev_ff       <= ev_in;
               other_ff    <= other_in;
               wr2_en_ff   <= wr2_en_in;
               wr2_addr_ff <= wr2_addr_in;
               wr2_data_ff <= wr2_data_in;
               state_ff    <= S_WR2;
            end
            S_WR2: begin
               // the second write repeats harmlessly while the response waits
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_event_ff <= ev_ff;
                  rsp_line_ff  <= a_ff;
                  rsp_other_ff <= other_ff;
                  wr2_en_ff    <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_res  = rsp_event_ff;
   assign rsp_line_id    = rsp_line_ff;
   assign rsp_other_line = rsp_other_ff;

endmodule

`default_nettype wire

FILE: hdl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks of the call state table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [cst_pkg::CMD_W-1:0]    req_command,
   input  logic [cst_pkg::LINE_W-1:0]   req_caller_line,
   input  logic [cst_pkg::LINE_W-1:0]   req_callee_line,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [cst_pkg::EVENT_W-1:0]  rsp_event_res,
   input  logic [cst_pkg::LINE_W-1:0]   rsp_line_id,
   input  logic [cst_pkg::LINE_W-1:0]   rsp_other_line
);

   import cst_pkg::*;

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // one command in flight: the request side closes after each beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a command is in flight");

   // event codes stay within the defined set
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= EV_ENDED)
      else $error("undefined event code");

   // a beat with no event carries no partner line
   a_none_other: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_NONE |-> rsp_other_line == '0)
      else $error("other line set on an empty event");

   // a stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res) &&
      $stable(rsp_line_id) && $stable(rsp_other_line))
      else $error("stalled response beat changed");

endmodule

bind call_state_table_top cst_checker u_cst_checker (.*);

`default_nettype wire

FILE: tb/call_state_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// call_state_table_checker
// Watches the request and response channels of the call state table, keeps
// its own copy of the per-line modes and partner links, predicts the event
// of every accepted command and compares it with the response beats in order.
// ----------------------------------------------------------------------------

module call_state_table_checker
   import cst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [LINE_W-1:0]   req_caller_line,
   input  logic [LINE_W-1:0]   req_callee_line,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [EVENT_W-1:0]  rsp_event_res,
   input  logic [LINE_W-1:0]   rsp_line_id,
   input  logic [LINE_W-1:0]   rsp_other_line,
   output int                  pending,
   output int                  fail_count
);

   typedef struct {
      event_type          ev;
      logic [LINE_W-1:0]  line;
      logic [LINE_W-1:0]  other;
   } call_event_type;

   // shadow of the exchange: mode and partner link per line
   mode_type           shadow_mode [NUM_LINES];
   logic [LINE_W-1:0]  shadow_peer [NUM_LINES];
   logic               shadow_linked [NUM_LINES];

   call_event_type     expected_events [$];

   // unlink a line and, if it has a partner, the partner too
   task automatic unlink_line(input logic [LINE_W-1:0] a);
      if (shadow_linked[a]) begin
         shadow_mode[shadow_peer[a]]   = MODE_IDLE;
         shadow_linked[shadow_peer[a]] = 1'b0;
         shadow_peer[shadow_peer[a]]   = '0;
      end
      shadow_mode[a]   = MODE_IDLE;
      shadow_linked[a] = 1'b0;
      shadow_peer[a]   = '0;
   endtask

   // apply one command to the shadow and work out the event it reports
   task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                input logic [LINE_W-1:0] a,
                                input logic [LINE_W-1:0] b,
                                output call_event_type result);
      mode_type           m;
      logic               linked;
      logic [LINE_W-1:0]  p;
      m      = shadow_mode[a];
      linked = shadow_linked[a];
      p      = linked ? shadow_peer[a] : '0;
      result.ev    = EV_NONE;
      result.line  = a;
      result.other = '0;
      case (cmd)
         CMD_CONNECT: begin
            if (b != a && m == MODE_IDLE) begin
               result.other = b;
               if (shadow_mode[b] == MODE_IDLE) begin
                  shadow_mode[a]   = MODE_WAITING;
                  shadow_mode[b]   = MODE_RINGING;
                  shadow_peer[a]   = b;
                  shadow_peer[b]   = a;
                  shadow_linked[a] = 1'b1;
                  shadow_linked[b] = 1'b1;
                  result.ev        = EV_RINGING;
               end else begin
                  result.ev = EV_BUSY;
               end
            end
         end
         CMD_ANSWER: begin
            if (m == MODE_RINGING && linked) begin
               shadow_mode[a] = MODE_TALKING;
               shadow_mode[p] = MODE_CONNECTED;
               result.ev      = EV_CONNECTED;
               result.other   = p;
            end
         end
         CMD_HANGUP: begin
            if (m == MODE_WAITING || m == MODE_RINGING ||
                m == MODE_CONNECTED || m == MODE_TALKING) begin
               if (linked) begin
                  if (m == MODE_RINGING)
                     result.ev = EV_REJECTED;
                  else if (m == MODE_WAITING)
                     result.ev = EV_ABANDONED;
                  else
                     result.ev = EV_ENDED;
                  result.other = p;
               end
               unlink_line(a);
            end
         end
         default: ;
      endcase
      if (result.ev == EV_NONE)
         result.other = '0;
   endtask

   // compare response beats first, then record the command of this edge
   always @(posedge clock) begin
      call_event_type want;
      call_event_type got;
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            shadow_mode[i]   = MODE_IDLE;
            shadow_peer[i]   = '0;
            shadow_linked[i] = 1'b0;
         end
         expected_events.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $error("response beat with no command waiting: event %0d line %0d",
                      rsp_event_res, rsp_line_id);
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_res !== want.ev) begin
                  $error("event_res: expected %0d, actual %0d", want.ev, rsp_event_res);
                  fail_count++;
               end
               if (rsp_line_id !== want.line) begin
                  $error("line_id: expected %0d, actual %0d", want.line, rsp_line_id);
                  fail_count++;
               end
               if (rsp_other_line !== want.other) begin
                  $error("other_line: expected %0d, actual %0d", want.other,
                         rsp_other_line);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_command(req_command, req_caller_line, req_callee_line, got);
            expected_events.push_back(got);
         end
      end
      pending = expected_events.size();
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the call state table: a directed pass over every command and
// corner case, then random call sequences mixed with noise, with random
// idling on both channels and one long response stall.
// ----------------------------------------------------------------------------

module tb_top;
   import cst_pkg::*;

   // command code outside the defined set, ignored by the block
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1040;
   localparam int QUIET_FROM   = 1000;
   localparam int PRESSURE_AT  = 200;
   localparam int PRESSURE_LEN = 300;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command;
   logic [LINE_W-1:0]   req_caller_line;
   logic [LINE_W-1:0]   req_callee_line;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [EVENT_W-1:0]  rsp_event_res;
   logic [LINE_W-1:0]   rsp_line_id;
   logic [LINE_W-1:0]   rsp_other_line;

   int                  pending;
   int                  fail_count;
   int                  useful_sent;
   logic                quiet;

   call_state_table_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_caller_line (req_caller_line),
      .req_callee_line (req_callee_line),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_line_id     (rsp_line_id),
      .rsp_other_line  (rsp_other_line)
   );

   call_state_table_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_caller_line (req_caller_line),
      .req_callee_line (req_callee_line),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_line_id     (rsp_line_id),
      .rsp_other_line  (rsp_other_line),
      .pending         (pending),
      .fail_count      (fail_count)
   );

   assign quiet = (useful_sent >= QUIET_FROM);

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // give up if the run hangs
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // response side: random stalls plus one long hold-off
   initial begin : rsp_side
      int  hold;
      bit  long_done;
      rsp_ready = 1'b0;
      hold      = 0;
      long_done = 0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (!long_done && useful_sent >= PRESSURE_AT) begin
            long_done = 1;
            hold      = PRESSURE_LEN - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 12) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one command beat, wait for it to be taken, then maybe idle
   task automatic issue(input logic [CMD_W-1:0] cmd,
                        input logic [LINE_W-1:0] a,
                        input logic [LINE_W-1:0] b);
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_caller_line <= a;
      req_callee_line <= b;
      do @(posedge clock); while (!req_ready);
      if (!(cmd == CMD_UNUSED || (cmd == CMD_CONNECT && a == b)))
         useful_sent++;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // random noise beat over the whole field ranges
   task automatic issue_noise();
      issue(CMD_W'($urandom_range(0, 3)), LINE_W'($urandom_range(0, 7)),
            LINE_W'($urandom_range(0, 7)));
   endtask

   initial begin : stimulus
      logic [LINE_W-1:0] a;
      logic [LINE_W-1:0] b;
      int                pick;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = CMD_CONNECT;
      req_caller_line = '0;
      req_callee_line = '0;
      useful_sent     = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every command, every event and the ignored cases
      issue(CMD_CONNECT, 3'd0, 3'd7);   // ringing
      issue(CMD_CONNECT, 3'd3, 3'd7);   // busy callee
      issue(CMD_CONNECT, 3'd5, 3'd5);   // self connect
      issue(CMD_UNUSED,  3'd6, 3'd1);   // undefined command
      issue(CMD_ANSWER,  3'd0, 3'd2);   // answer on a waiting line
      issue(CMD_ANSWER,  3'd7, 3'd0);   // connected
      issue(CMD_ANSWER,  3'd7, 3'd0);   // answer again, ignored
      issue(CMD_CONNECT, 3'd0, 3'd4);   // connect from a busy line
      issue(CMD_CONNECT, 3'd2, 3'd0);   // busy
      issue(CMD_HANGUP,  3'd0, 3'd3);   // ended by the caller
      issue(CMD_HANGUP,  3'd0, 3'd3);   // hang up while idle
      issue(CMD_CONNECT, 3'd6, 3'd1);
      issue(CMD_HANGUP,  3'd1, 3'd0);   // rejected
      issue(CMD_CONNECT, 3'd6, 3'd1);
      issue(CMD_HANGUP,  3'd6, 3'd0);   // abandoned
      issue(CMD_CONNECT, 3'd2, 3'd5);
      issue(CMD_ANSWER,  3'd5, 3'd0);
      issue(CMD_HANGUP,  3'd5, 3'd0);   // ended by the callee
      issue(CMD_CONNECT, 3'd7, 3'd0);
      issue(CMD_ANSWER,  3'd0, 3'd6);
      issue(CMD_HANGUP,  3'd7, 3'd0);   // ended, caller side
      issue(CMD_UNUSED,  3'd7, 3'd7);
      useful_sent = 0;

      // random: mostly whole calls, some noise and broken sequences
      while (useful_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         a    = LINE_W'($urandom_range(0, 7));
         b    = a + LINE_W'($urandom_range(1, 7));
         if (pick < 60) begin
            issue(CMD_CONNECT, a, b);
            if ($urandom_range(0, 3) == 0)
               issue_noise();
            if ($urandom_range(0, 2) != 0)
               issue(CMD_ANSWER, b, LINE_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 4) != 0)
               issue(CMD_HANGUP, $urandom_range(0, 1) ? a : b,
                     LINE_W'($urandom_range(0, 7)));
         end else if (pick < 90) begin
            issue_noise();
         end else if (pick < 95) begin
            issue(CMD_ANSWER, a, b);
            issue(CMD_HANGUP, b, a);
         end else begin
            issue(CMD_CONNECT, a, a);
         end
      end
      req_valid <= 1'b0;

      // drain, then allow the pipeline to settle
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
